FILE: rtl/core/ptcd_pkg.sv
package ptcd_pkg;

  localparam int CoordW = 24;
  localparam int SizeW  = 23;
  // Doubled coordinate offsets plus or minus the size need 27 signed bits.
  localparam int AxisW  = 28;
  localparam int MagW   = 26;
  localparam int SqW    = 2 * MagW;
  localparam int SumW   = SqW + 2;
  localparam int RootW  = SumW / 2;
  localparam int DistW  = RootW - 1;

  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

endpackage

FILE: rtl/core/ptcd_axis_lane.sv
module ptcd_axis_lane (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [ptcd_pkg::CoordW-1:0]   point,
  input  logic signed [ptcd_pkg::CoordW-1:0]   center,
  input  logic        [ptcd_pkg::SizeW-1:0]    cube_size,
  output logic        [ptcd_pkg::SqW-1:0]      sq
);
  import ptcd_pkg::*;

  logic signed [AxisW-1:0] diff2;
  logic signed [AxisW-1:0] lo;
  logic signed [AxisW-1:0] hi;
  logic        [AxisW-1:0] lo_mag;
  logic        [AxisW-1:0] hi_mag;
  logic                    in_box;
  logic        [MagW-1:0]  dist_nxt;
  logic        [MagW-1:0]  dist_r;
  logic        [SqW-1:0]   sq_r;

  assign diff2 = {{(AxisW-CoordW-1){point[CoordW-1]}}, point, 1'b0}
               - {{(AxisW-CoordW-1){center[CoordW-1]}}, center, 1'b0};
  assign lo = diff2 + $signed({{(AxisW-SizeW){1'b0}}, cube_size});
  assign hi = diff2 - $signed({{(AxisW-SizeW){1'b0}}, cube_size});

  assign lo_mag = lo[AxisW-1] ? AxisW'(-lo) : AxisW'(lo);
  assign hi_mag = hi[AxisW-1] ? AxisW'(-hi) : AxisW'(hi);
  // Strictly above the low face and at or below the high face is inside.
  assign in_box = (lo > 0) && (hi <= 0);

  always_comb begin
    if (in_box) begin
      dist_nxt = '0;
    end else if (lo_mag < hi_mag) begin
      dist_nxt = lo_mag[MagW-1:0];
    end else begin
      dist_nxt = hi_mag[MagW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
      sq_r   <= SqW'(dist_r) * SqW'(dist_r);
    end
  end

  assign sq = sq_r;

endmodule

FILE: rtl/core/ptcd_merge.sv
module ptcd_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptcd_pkg::stage_ctl_t           ctl_in,
  input  logic [ptcd_pkg::SqW-1:0]       sq_x,
  input  logic [ptcd_pkg::SqW-1:0]       sq_y,
  input  logic [ptcd_pkg::SqW-1:0]       sq_z,
  output logic                           sum_vld,
  output logic [ptcd_pkg::SumW-1:0]      sum
);
  import ptcd_pkg::*;

  logic            vld_r;
  logic [SumW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_in.adv) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.adv) begin
      sum_r <= SumW'(sq_x) + SumW'(sq_y) + SumW'(sq_z);
    end
  end

  assign sum_vld = vld_r;
  assign sum     = sum_r;

endmodule

FILE: rtl/core/ptcd_isqrt.sv
module ptcd_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ptcd_pkg::stage_ctl_t           ctl_in,
  input  logic [ptcd_pkg::SumW-1:0]      radicand,
  output logic                           root_vld,
  output logic [ptcd_pkg::RootW-1:0]     root
);
  import ptcd_pkg::*;

  localparam int ExtW = SumW + 2;

  logic [SumW-1:0]  rem_w  [RootW+1];
  logic [RootW-1:0] root_w [RootW+1];
  logic             vld_w  [RootW+1];

  assign rem_w[0]  = radicand;
  assign root_w[0] = '0;
  assign vld_w[0]  = ctl_in.vld;

  // One result bit per stage, most significant first. rem holds the
  // radicand minus the square of the partial root.
  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int K = RootW - 1 - j;
    logic [ExtW-1:0]  trial;
    logic [ExtW-1:0]  rem_ext;
    logic             take;
    logic [SumW-1:0]  rem_r;
    logic [RootW-1:0] root_r;
    logic             vld_r;

    assign trial   = ({{(ExtW-RootW){1'b0}}, root_w[j]} << (K + 1))
                   + (ExtW'(1) << (2 * K));
    assign rem_ext = {2'b00, rem_w[j]};
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (ctl_in.adv) begin
        vld_r <= vld_w[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_in.adv) begin
        rem_r  <= take ? SumW'(rem_ext - trial) : rem_w[j];
        root_r <= take ? (root_w[j] | (RootW'(1) << K)) : root_w[j];
      end
    end

    assign rem_w[j+1]  = rem_r;
    assign root_w[j+1] = root_r;
    assign vld_w[j+1]  = vld_r;
  end

  assign root_vld = vld_w[RootW];
  assign root     = root_w[RootW];

endmodule

FILE: rtl/core/point_to_cube_distance.sv
// An input transfer passes through the per-axis lanes (distance register,
// then square register), the sum of squares and the square root pipeline.
// Throughput: one item per cycle while the result side does not stall; a
// stalled result freezes the whole pipeline.
// Reset clears all valid flags; data registers are not reset.
module point_to_cube_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_point_x,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_point_y,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_point_z,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_center_x,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_center_y,
  input  logic signed [ptcd_pkg::CoordW-1:0]  in_center_z,
  input  logic        [ptcd_pkg::SizeW-1:0]   in_cube_size,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [ptcd_pkg::DistW-1:0]   out_distance
);
  import ptcd_pkg::*;

  logic             adv;
  logic             v1_r;
  logic             v2_r;
  logic [SqW-1:0]   sq_x;
  logic [SqW-1:0]   sq_y;
  logic [SqW-1:0]   sq_z;
  logic             sum_vld;
  logic [SumW-1:0]  sum;
  logic             root_vld;
  logic [RootW-1:0] root;
  stage_ctl_t       merge_ctl;
  stage_ctl_t       sqrt_ctl;

  // The last square root stage is the output register.
  assign adv      = !root_vld || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  ptcd_axis_lane u_lane_x (
    .clk       (clk),
    .adv       (adv),
    .point     (in_point_x),
    .center    (in_center_x),
    .cube_size (in_cube_size),
    .sq        (sq_x)
  );

  ptcd_axis_lane u_lane_y (
    .clk       (clk),
    .adv       (adv),
    .point     (in_point_y),
    .center    (in_center_y),
    .cube_size (in_cube_size),
    .sq        (sq_y)
  );

  ptcd_axis_lane u_lane_z (
    .clk       (clk),
    .adv       (adv),
    .point     (in_point_z),
    .center    (in_center_z),
    .cube_size (in_cube_size),
    .sq        (sq_z)
  );

  assign merge_ctl.adv = adv;
  assign merge_ctl.vld = v2_r;

  ptcd_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (merge_ctl),
    .sq_x    (sq_x),
    .sq_y    (sq_y),
    .sq_z    (sq_z),
    .sum_vld (sum_vld),
    .sum     (sum)
  );

  assign sqrt_ctl.adv = adv;
  assign sqrt_ctl.vld = sum_vld;

  ptcd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (sqrt_ctl),
    .radicand (sum),
    .root_vld (root_vld),
    .root     (root)
  );

  // Coordinates were doubled, so the root is halved.
  assign out_valid    = root_vld;
  assign out_distance = root[RootW-1:1];

endmodule
